// ----- rtl/pcxd_pkg.sv -----
// ----------------------------------------------------------------------------
// PCX decoder package
// Shared types, codes and sizes for the PCX image stream decoder.
// ----------------------------------------------------------------------------
package pcxd_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int LINE_AW     = $clog2(MAX_WIDTH);
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] RLE_MARK     = 8'hC0;
    localparam logic [7:0] PAL_MARKER   = 8'd12;
    localparam logic [3:0] MARKER_TRIES = 4'd8;
    localparam logic [6:0] HEADER_LAST  = 7'd127;
    localparam logic [7:0] PAL_LAST     = 8'd255;

    localparam logic [3:0] ERR_TRUNCATED = 4'd0;
    localparam logic [3:0] ERR_MANUF     = 4'd1;
    localparam logic [3:0] ERR_VERSION   = 4'd2;
    localparam logic [3:0] ERR_ENCODING  = 4'd3;
    localparam logic [3:0] ERR_BPP       = 4'd4;
    localparam logic [3:0] ERR_PLANES    = 4'd5;
    localparam logic [3:0] ERR_WIDTH     = 4'd6;
    localparam logic [3:0] ERR_HEIGHT    = 4'd7;
    localparam logic [3:0] ERR_LINEBYTES = 4'd8;
    localparam logic [3:0] ERR_OVERRUN   = 4'd9;
    localparam logic [3:0] ERR_NOMARKER  = 4'd10;
    localparam logic [3:0] ERR_TOOWIDE   = 4'd11;

    typedef enum logic [2:0] {
        PH_HEADER, PH_PIXELS, PH_MARKER, PH_PALETTE, PH_DONE, PH_ERROR
    } phase_t;

    typedef enum logic [1:0] {
        KIND_HEADER, KIND_PIXEL, KIND_PALETTE, KIND_ERROR
    } kind_t;

    // How the back end treats each beat of a command.
    typedef enum logic [1:0] {
        MODE_EMIT, MODE_WR_RED, MODE_WR_GREEN, MODE_RGB
    } mode_t;

    typedef struct packed {
        mode_t       mode;
        kind_t       kind;
        logic [5:0]  count;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [15:0] column;
        logic [16:0] row;
        logic [15:0] dpi_x;
        logic [15:0] dpi_y;
        logic [3:0]  error_code;
        logic        image_end;
    } cmd_t;

    function automatic cmd_t make_error(input logic [3:0] code);
        cmd_t c;
        c            = '0;
        c.mode       = MODE_EMIT;
        c.kind       = KIND_ERROR;
        c.count      = 6'd1;
        c.error_code = code;
        c.image_end  = 1'b1;
        return c;
    endfunction

endpackage

// ----- rtl/pcxd_front.sv -----
// ----------------------------------------------------------------------------
// PCX decoder front end
// Parses the header, tracks RLE and line position, issues at most one command per byte.
// ----------------------------------------------------------------------------
module pcxd_front
    import pcxd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_eof,
    output logic       push,
    output cmd_t       push_cmd,
    input  logic       q_full
);

    phase_t      phase_reg, phase_next;
    logic [6:0]  hdr_cnt_reg, hdr_cnt_next;
    logic [31:0] ids_reg, ids_next;
    logic [15:0] min_x_reg, min_x_next, min_y_reg, min_y_next;
    logic [15:0] max_x_reg, max_x_next, max_y_reg, max_y_next;
    logic [15:0] line_bytes_reg, line_bytes_next;
    logic [1:0]  planes_reg, planes_next;
    logic [31:0] dpi_reg, dpi_next;
    logic        fill_reg, fill_next;
    logic [5:0]  run_reg, run_next;
    logic [15:0] left_reg, left_next;
    logic [15:0] col_reg, col_next;
    logic [16:0] row_reg, row_next;
    logic [1:0]  plane_reg, plane_next;
    logic [3:0]  scan_reg, scan_next;
    logic [1:0]  comp_reg, comp_next;
    logic [7:0]  entry_reg, entry_next;
    logic [15:0] staged_reg, staged_next;

    logic        acc;
    logic [16:0] width, height;
    logic        do_fill;
    logic [5:0]  fill_n;
    logic [16:0] c_end, emit_end, n_eff;
    logic [15:0] left_after;
    cmd_t        cmd;
    logic        cmd_ok;

    assign in_ready = !q_full;
    assign acc      = in_valid && !q_full;
    assign width    = (max_x_reg >= min_x_reg) ?
                      ({1'b0, max_x_reg} - {1'b0, min_x_reg} + 17'd1) : 17'd0;
    assign height   = (max_y_reg >= min_y_reg) ?
                      ({1'b0, max_y_reg} - {1'b0, min_y_reg} + 17'd1) : 17'd0;
    assign c_end    = {1'b0, col_reg} + {11'd0, fill_n};
    assign emit_end = (c_end > width) ? width : c_end;
    assign n_eff    = ({1'b0, col_reg} < width) ? (emit_end - {1'b0, col_reg}) : 17'd0;
    assign left_after = left_reg - {10'd0, fill_n};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_HEADER;
            hdr_cnt_reg    <= '0;
            ids_reg        <= '0;
            min_x_reg      <= '0;
            min_y_reg      <= '0;
            max_x_reg      <= '0;
            max_y_reg      <= '0;
            line_bytes_reg <= '0;
            planes_reg     <= '0;
            dpi_reg        <= '0;
            fill_reg       <= 1'b0;
            run_reg        <= '0;
            left_reg       <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
            plane_reg      <= '0;
            scan_reg       <= '0;
            comp_reg       <= '0;
            entry_reg      <= '0;
            staged_reg     <= '0;
        end else begin
            phase_reg      <= phase_next;
            hdr_cnt_reg    <= hdr_cnt_next;
            ids_reg        <= ids_next;
            min_x_reg      <= min_x_next;
            min_y_reg      <= min_y_next;
            max_x_reg      <= max_x_next;
            max_y_reg      <= max_y_next;
            line_bytes_reg <= line_bytes_next;
            planes_reg     <= planes_next;
            dpi_reg        <= dpi_next;
            fill_reg       <= fill_next;
            run_reg        <= run_next;
            left_reg       <= left_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            plane_reg      <= plane_next;
            scan_reg       <= scan_next;
            comp_reg       <= comp_next;
            entry_reg      <= entry_next;
            staged_reg     <= staged_next;
        end
    end

    always_comb begin
        phase_next      = phase_reg;
        hdr_cnt_next    = hdr_cnt_reg;
        ids_next        = ids_reg;
        min_x_next      = min_x_reg;
        min_y_next      = min_y_reg;
        max_x_next      = max_x_reg;
        max_y_next      = max_y_reg;
        line_bytes_next = line_bytes_reg;
        planes_next     = planes_reg;
        dpi_next        = dpi_reg;
        fill_next       = fill_reg;
        run_next        = run_reg;
        left_next       = left_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        plane_next      = plane_reg;
        scan_next       = scan_reg;
        comp_next       = comp_reg;
        entry_next      = entry_reg;
        staged_next     = staged_reg;
        cmd             = '0;
        cmd_ok          = 1'b0;
        do_fill         = 1'b0;
        fill_n          = '0;

        if (acc) begin
            unique case (phase_reg)
                PH_HEADER: begin
                    case (hdr_cnt_reg)
                        7'd0:  ids_next[7:0]        = in_byte;
                        7'd1:  ids_next[15:8]       = in_byte;
                        7'd2:  ids_next[23:16]      = in_byte;
                        7'd3:  ids_next[31:24]      = in_byte;
                        7'd4:  min_x_next[7:0]      = in_byte;
                        7'd5:  min_x_next[15:8]     = in_byte;
                        7'd6:  min_y_next[7:0]      = in_byte;
                        7'd7:  min_y_next[15:8]     = in_byte;
                        7'd8:  max_x_next[7:0]      = in_byte;
                        7'd9:  max_x_next[15:8]     = in_byte;
                        7'd10: max_y_next[7:0]      = in_byte;
                        7'd11: max_y_next[15:8]     = in_byte;
                        7'd12: dpi_next[7:0]        = in_byte;
                        7'd13: dpi_next[15:8]       = in_byte;
                        7'd14: dpi_next[23:16]      = in_byte;
                        7'd15: dpi_next[31:24]      = in_byte;
                        7'd65: planes_next = (in_byte == 8'd1) ? 2'd1 :
                                             ((in_byte == 8'd3) ? 2'd3 : 2'd0);
                        7'd66: line_bytes_next[7:0]  = in_byte;
                        7'd67: line_bytes_next[15:8] = in_byte;
                        default: ;
                    endcase
                    hdr_cnt_next = hdr_cnt_reg + 7'd1;
                    if (hdr_cnt_reg == HEADER_LAST) begin
                        cmd_ok = 1'b1;
                        priority if (ids_reg[7:0] != 8'd10) begin
                            cmd = make_error(ERR_MANUF);
                        end else if (ids_reg[15:8] != 8'd5) begin
                            cmd = make_error(ERR_VERSION);
                        end else if (ids_reg[23:16] != 8'd1) begin
                            cmd = make_error(ERR_ENCODING);
                        end else if (ids_reg[31:24] != 8'd8) begin
                            cmd = make_error(ERR_BPP);
                        end else if (planes_reg == 2'd0) begin
                            cmd = make_error(ERR_PLANES);
                        end else if (width == 17'd0) begin
                            cmd = make_error(ERR_WIDTH);
                        end else if (height == 17'd0) begin
                            cmd = make_error(ERR_HEIGHT);
                        end else if ({1'b0, line_bytes_reg} != ((width + 17'd1) & ~17'd1)) begin
                            cmd = make_error(ERR_LINEBYTES);
                        end else if (planes_reg == 2'd3 && width > 17'(MAX_WIDTH)) begin
                            cmd = make_error(ERR_TOOWIDE);
                        end else begin
                            cmd.mode   = MODE_EMIT;
                            cmd.kind   = KIND_HEADER;
                            cmd.count  = 6'd1;
                            cmd.column = width[15:0];
                            cmd.row    = height;
                            cmd.dpi_x  = dpi_reg[15:0];
                            cmd.dpi_y  = dpi_reg[31:16];
                        end
                        if (cmd.kind == KIND_ERROR) begin
                            phase_next = PH_ERROR;
                        end else begin
                            phase_next = PH_PIXELS;
                            left_next  = line_bytes_reg;
                            col_next   = '0;
                            row_next   = '0;
                            plane_next = '0;
                            fill_next  = 1'b0;
                            run_next   = '0;
                        end
                    end
                end
                PH_PIXELS: begin
                    if (fill_reg) begin
                        fill_n    = run_reg;
                        fill_next = 1'b0;
                        run_next  = '0;
                        do_fill   = 1'b1;
                    end else if (in_byte < RLE_MARK) begin
                        fill_n  = 6'd1;
                        do_fill = 1'b1;
                    end else if (in_byte[5:0] != 6'd0) begin
                        if ({10'd0, in_byte[5:0]} > left_reg) begin
                            cmd        = make_error(ERR_OVERRUN);
                            cmd_ok     = 1'b1;
                            phase_next = PH_ERROR;
                        end else begin
                            fill_next = 1'b1;
                            run_next  = in_byte[5:0];
                        end
                    end
                end
                PH_MARKER: begin
                    if (in_byte == PAL_MARKER) begin
                        phase_next  = PH_PALETTE;
                        comp_next   = '0;
                        entry_next  = '0;
                        staged_next = '0;
                    end else begin
                        scan_next = scan_reg + 4'd1;
                        if (scan_next >= MARKER_TRIES) begin
                            cmd        = make_error(ERR_NOMARKER);
                            cmd_ok     = 1'b1;
                            phase_next = PH_ERROR;
                        end
                    end
                end
                PH_PALETTE: begin
                    unique case (comp_reg)
                        2'd0: begin
                            staged_next[7:0] = in_byte;
                            comp_next        = 2'd1;
                        end
                        2'd1: begin
                            staged_next[15:8] = in_byte;
                            comp_next         = 2'd2;
                        end
                        default: begin
                            cmd.mode      = MODE_EMIT;
                            cmd.kind      = KIND_PALETTE;
                            cmd.count     = 6'd1;
                            cmd.red       = staged_reg[7:0];
                            cmd.green     = staged_reg[15:8];
                            cmd.blue      = in_byte;
                            cmd.column    = {8'd0, entry_reg};
                            cmd.image_end = (entry_reg == PAL_LAST);
                            cmd_ok        = 1'b1;
                            comp_next     = 2'd0;
                            entry_next    = entry_reg + 8'd1;
                            if (entry_reg == PAL_LAST) begin
                                phase_next = PH_DONE;
                            end
                        end
                    endcase
                end
                default: ;
            endcase

            // A run never crosses a plane line, so one command covers it.
            if (do_fill) begin
                cmd.kind   = KIND_PIXEL;
                cmd.count  = n_eff[5:0];
                cmd.column = col_reg;
                cmd.row    = row_reg;
                if (planes_reg == 2'd1) begin
                    cmd.mode = MODE_EMIT;
                    cmd.red  = in_byte;
                end else if (plane_reg == 2'd0) begin
                    cmd.mode = MODE_WR_RED;
                    cmd.red  = in_byte;
                end else if (plane_reg == 2'd1) begin
                    cmd.mode = MODE_WR_GREEN;
                    cmd.red  = in_byte;
                end else begin
                    cmd.mode      = MODE_RGB;
                    cmd.blue      = in_byte;
                    cmd.image_end = (row_reg + 17'd1 == height) && (emit_end == width);
                end
                cmd_ok = (n_eff != 17'd0);
                if (left_after == 16'd0) begin
                    col_next  = '0;
                    left_next = line_bytes_reg;
                    if (planes_reg == 2'd3 && plane_reg < 2'd2) begin
                        plane_next = plane_reg + 2'd1;
                    end else begin
                        plane_next = '0;
                        row_next   = row_reg + 17'd1;
                        if (row_next == height) begin
                            phase_next = (planes_reg == 2'd1) ? PH_MARKER : PH_DONE;
                            scan_next  = '0;
                        end
                    end
                end else begin
                    col_next  = c_end[15:0];
                    left_next = left_after;
                end
            end

            // The end-of-file byte always rearms; an unfinished image reports truncation.
            if (in_eof) begin
                if (phase_reg != PH_ERROR && phase_next != PH_ERROR && phase_next != PH_DONE) begin
                    cmd    = make_error(ERR_TRUNCATED);
                    cmd_ok = 1'b1;
                end
                phase_next      = PH_HEADER;
                hdr_cnt_next    = '0;
                ids_next        = '0;
                min_x_next      = '0;
                min_y_next      = '0;
                max_x_next      = '0;
                max_y_next      = '0;
                line_bytes_next = '0;
                planes_next     = '0;
                dpi_next        = '0;
                fill_next       = 1'b0;
                run_next        = '0;
                left_next       = '0;
                col_next        = '0;
                row_next        = '0;
                plane_next      = '0;
                scan_next       = '0;
                comp_next       = '0;
                entry_next      = '0;
                staged_next     = '0;
            end
        end
    end

    assign push     = cmd_ok;
    assign push_cmd = cmd;

endmodule

// ----- rtl/pcxd_cmd_fifo.sv -----
// ----------------------------------------------------------------------------
// PCX decoder command queue
// Short queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module pcxd_cmd_fifo
    import pcxd_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    output logic not_empty,
    input  logic pop,
    output cmd_t head
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    cmd_t          mem [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign full      = (count_reg == CW'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("command queue count out of range");
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("push into full command queue");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && !not_empty))
        else $error("pop from empty command queue");

endmodule

// ----- rtl/pcxd_back.sv -----
// ----------------------------------------------------------------------------
// PCX decoder back end
// Expands commands into result beats, owns the red and green line stores.
// ----------------------------------------------------------------------------
module pcxd_back
    import pcxd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    input  cmd_t        q_cmd,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  out_kind,
    output logic [7:0]  out_red,
    output logic [7:0]  out_green,
    output logic [7:0]  out_blue,
    output logic [15:0] out_column,
    output logic [16:0] out_row,
    output logic [15:0] out_dpi_x,
    output logic [15:0] out_dpi_y,
    output logic [3:0]  out_error,
    output logic        out_run_end,
    output logic        out_image_end
);

    logic [7:0] red_mem   [MAX_WIDTH];
    logic [7:0] green_mem [MAX_WIDTH];

    cmd_t        cur_reg;
    logic [5:0]  cnt_reg;
    logic        valid_reg, rgb_reg;
    logic [7:0]  red_q_reg, green_q_reg;
    cmd_t        res_reg;
    logic        run_end_reg, image_end_reg;

    logic               emits, slot_free, step, last_beat;
    logic [LINE_AW-1:0] addr;

    assign emits     = (cur_reg.mode == MODE_EMIT) || (cur_reg.mode == MODE_RGB);
    assign slot_free = !valid_reg || out_ready;
    assign step      = (cnt_reg != '0) && (!emits || slot_free);
    assign last_beat = (cnt_reg == 6'd1);
    assign q_pop     = q_valid && ((cnt_reg == '0) || (step && last_beat));
    assign addr      = cur_reg.column[LINE_AW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (q_pop) begin
                cnt_reg <= q_cmd.count;
            end else if (step) begin
                cnt_reg <= cnt_reg - 6'd1;
            end
            if (step && emits) begin
                valid_reg <= 1'b1;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_reg <= q_cmd;
        end else if (step) begin
            cur_reg.column <= cur_reg.column + 16'd1;
        end
        if (step && emits) begin
            res_reg       <= cur_reg;
            rgb_reg       <= (cur_reg.mode == MODE_RGB);
            run_end_reg   <= last_beat;
            image_end_reg <= cur_reg.image_end && last_beat;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && cur_reg.mode == MODE_WR_RED) begin
            red_mem[addr] <= cur_reg.red;
        end
        if (step && cur_reg.mode == MODE_RGB) begin
            red_q_reg <= red_mem[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (step && cur_reg.mode == MODE_WR_GREEN) begin
            green_mem[addr] <= cur_reg.red;
        end
        if (step && cur_reg.mode == MODE_RGB) begin
            green_q_reg <= green_mem[addr];
        end
    end

    assign out_valid     = valid_reg;
    assign out_kind      = res_reg.kind;
    assign out_red       = rgb_reg ? red_q_reg : res_reg.red;
    assign out_green     = rgb_reg ? green_q_reg : res_reg.green;
    assign out_blue      = res_reg.blue;
    assign out_column    = res_reg.column;
    assign out_row       = res_reg.row;
    assign out_dpi_x     = res_reg.dpi_x;
    assign out_dpi_y     = res_reg.dpi_y;
    assign out_error     = res_reg.error_code;
    assign out_run_end   = run_end_reg;
    assign out_image_end = image_end_reg;

endmodule

// ----- rtl/pcx_image_stream_decoder.sv -----
// ----------------------------------------------------------------------------
// PCX image stream decoder
// Decodes an 8-bit RLE PCX file, one byte per beat, into header, pixel,
// palette and error results.
// ----------------------------------------------------------------------------
// Usage:
// The slave channel takes one file byte per beat in s_tdata; s_tlast marks
// the final byte of the file, after which the decoder rearms for a header.
// The master channel returns result beats: m_tuser carries the kind and the
// image-end flag, m_tlast marks the last result caused by one input byte.
// A front end parses the header and tracks RLE and line position, issuing
// at most one command per byte into a two-entry queue. The back end expands
// each command into beats, one per cycle but for stalls on a held output,
// through the red and green line stores. A literal byte gives one beat; the
// value byte of a run gives up to 63 pixel beats, and once the queue has
// filled behind it s_tready drops. An accepted byte's first result passes
// through the queue, the back end's command register and the output register.
// Pad and store-only bytes give no result.
// A synchronous active-low reset returns to header collection with empty
// queue and output. When m_tready is low the output register holds, the
// queue fills, and s_tready drops; nothing is lost.
// ----------------------------------------------------------------------------
module pcx_image_stream_decoder
    import pcxd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // end_of_file
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] red_or_index, [15:8] green, [23:16] blue, [39:24] column,
    // [56:40] row, [72:57] dpi_x, [88:73] dpi_y, [92:89] error_code, zero pad
    output logic [95:0] m_tdata,
    output logic [2:0]  m_tuser,   // [1:0] kind, [2] image_end
    output logic        m_tlast    // run_end
);

    logic        push, q_full, q_not_empty, q_pop;
    cmd_t        push_cmd, q_head;
    logic [1:0]  kind;
    logic [7:0]  red, green, blue;
    logic [15:0] column, dpi_x, dpi_y;
    logic [16:0] row;
    logic [3:0]  error_code;
    logic        run_end, image_end;

    // Header parsing and stream position tracking.
    pcxd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata),
        .in_eof   (s_tlast),
        .push     (push),
        .push_cmd (push_cmd),
        .q_full   (q_full)
    );

    // Decoupling queue between the two halves.
    pcxd_cmd_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .not_empty (q_not_empty),
        .pop       (q_pop),
        .head      (q_head)
    );

    // Run expansion, RGB merge and output register.
    pcxd_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_not_empty),
        .q_cmd         (q_head),
        .q_pop         (q_pop),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_kind      (kind),
        .out_red       (red),
        .out_green     (green),
        .out_blue      (blue),
        .out_column    (column),
        .out_row       (row),
        .out_dpi_x     (dpi_x),
        .out_dpi_y     (dpi_y),
        .out_error     (error_code),
        .out_run_end   (run_end),
        .out_image_end (image_end)
    );

    assign m_tdata = {3'b000, error_code, dpi_y, dpi_x, row, column, blue, green, red};
    assign m_tuser = {image_end, kind};
    assign m_tlast = run_end;

endmodule

// ----- sim/tb_pcx_image_stream_decoder.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PCX image stream decoder testbench
// Sends PCX files, whole or cut off, as byte beats and checks every result
// beat against a cycle-free predictor of the decoder.
// ----------------------------------------------------------------------------
module tb_pcx_image_stream_decoder;
    import pcxd_pkg::*;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [15:0] column;
        logic [16:0] row;
        logic [15:0] dpi_x;
        logic [15:0] dpi_y;
        logic [3:0]  error_code;
        logic        run_end;
        logic        image_end;
    } pcx_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    pcx_image_stream_decoder dut (.*);

    always #5 aclk = ~aclk;

    // Predictor state.
    phase_t      ph;
    int unsigned hdr_cnt, hdr_ids, mnx, mny, mxx, mxy, lbytes, planes, dpis;
    int unsigned fill, runc, left, col, rowp, plane, mscan, ppos, pstage;
    logic [7:0]  red_store [MAX_WIDTH];
    logic [7:0]  green_store [MAX_WIDTH];

    pcx_result_t decoded_q[$];
    pcx_result_t step_res[$];
    int          errors = 0;
    int          beats_sent = 0;
    int          beats_seen = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_recv = 0;

    function automatic void clear_decoder();
        ph = PH_HEADER; hdr_cnt = 0; hdr_ids = 0;
        mnx = 0; mny = 0; mxx = 0; mxy = 0; lbytes = 0; planes = 0; dpis = 0;
        fill = 0; runc = 0; left = 0; col = 0; rowp = 0; plane = 0;
        mscan = 0; ppos = 0; pstage = 0;
    endfunction

    function automatic void emit(kind_t k, int unsigned r, int unsigned g,
                                 int unsigned b, int unsigned c, int unsigned rw,
                                 int unsigned dx, int unsigned dy,
                                 logic [3:0] ec, logic iend);
        pcx_result_t x;
        x = '0;
        x.kind = k; x.red = 8'(r); x.green = 8'(g); x.blue = 8'(b); x.column = 16'(c);
        x.row = 17'(rw); x.dpi_x = 16'(dx); x.dpi_y = 16'(dy); x.error_code = ec;
        x.image_end = iend;
        step_res.push_back(x);
    endfunction

    function automatic void raise_error(logic [3:0] ec);
        emit(KIND_ERROR, 0, 0, 0, 0, 0, 0, 0, ec, 1'b1);
        ph = PH_ERROR;
    endfunction

    function automatic int unsigned width_of();
        return (mxx >= mnx) ? mxx - mnx + 1 : 0;
    endfunction

    function automatic int unsigned height_of();
        return (mxy >= mny) ? mxy - mny + 1 : 0;
    endfunction

    function automatic void take_header(int unsigned v);
        int unsigned w, h;
        if (hdr_cnt < 4) hdr_ids |= v << (8 * hdr_cnt);
        else if (hdr_cnt < 12) begin
            case ((hdr_cnt - 4) >> 1)
                0: mnx = (hdr_cnt & 1) ? (mnx & 8'hFF) | (v << 8) : (mnx & 16'hFF00) | v;
                1: mny = (hdr_cnt & 1) ? (mny & 8'hFF) | (v << 8) : (mny & 16'hFF00) | v;
                2: mxx = (hdr_cnt & 1) ? (mxx & 8'hFF) | (v << 8) : (mxx & 16'hFF00) | v;
                default: mxy = (hdr_cnt & 1) ? (mxy & 8'hFF) | (v << 8)
                                             : (mxy & 16'hFF00) | v;
            endcase
        end else if (hdr_cnt < 16) begin
            dpis = (dpis & ~(32'hFF << (8 * (hdr_cnt - 12)))) | (v << (8 * (hdr_cnt - 12)));
        end else if (hdr_cnt == 65) planes = (v == 1) ? 1 : ((v == 3) ? 3 : 0);
        else if (hdr_cnt == 66) lbytes = (lbytes & 16'hFF00) | v;
        else if (hdr_cnt == 67) lbytes = (lbytes & 8'hFF) | (v << 8);
        hdr_cnt++;
        if (hdr_cnt < 128) return;
        w = width_of();
        h = height_of();
        if ((hdr_ids & 8'hFF) != 10) raise_error(ERR_MANUF);
        else if (((hdr_ids >> 8) & 8'hFF) != 5) raise_error(ERR_VERSION);
        else if (((hdr_ids >> 16) & 8'hFF) != 1) raise_error(ERR_ENCODING);
        else if (((hdr_ids >> 24) & 8'hFF) != 8) raise_error(ERR_BPP);
        else if (planes == 0) raise_error(ERR_PLANES);
        else if (w == 0) raise_error(ERR_WIDTH);
        else if (h == 0) raise_error(ERR_HEIGHT);
        else if (lbytes != ((w + 1) & ~32'd1)) raise_error(ERR_LINEBYTES);
        else if (planes == 3 && w > MAX_WIDTH) raise_error(ERR_TOOWIDE);
        else begin
            emit(KIND_HEADER, 0, 0, 0, w, h, dpis & 16'hFFFF, dpis >> 16, 0, 1'b0);
            ph = PH_PIXELS; left = lbytes;
            col = 0; rowp = 0; plane = 0; fill = 0; runc = 0;
        end
    endfunction

    // One decoded byte landing in the current plane line.
    function automatic void place_line_byte(int unsigned v);
        int unsigned w, h;
        w = width_of();
        h = height_of();
        if (col < w) begin
            if (planes == 1) emit(KIND_PIXEL, v, 0, 0, col, rowp, 0, 0, 0, 1'b0);
            else if (col < MAX_WIDTH) begin
                if (plane == 0) red_store[col] = 8'(v);
                else if (plane == 1) green_store[col] = 8'(v);
                else emit(KIND_PIXEL, red_store[col], green_store[col], v, col, rowp,
                          0, 0, 0, (rowp + 1 == h && col + 1 == w));
            end
        end
        col = (col + 1) & 16'hFFFF;
        left = (left - 1) & 16'hFFFF;
        if (left != 0) return;
        col = 0;
        left = lbytes;
        if (planes == 3 && plane < 2) begin
            plane++;
            return;
        end
        plane = 0;
        rowp = (rowp + 1) & 17'h1FFFF;
        if (rowp == h) begin
            ph = (planes == 1) ? PH_MARKER : PH_DONE;
            mscan = 0;
        end
    endfunction

    function automatic void predict_byte(int unsigned v, logic eof);
        phase_t start_ph;
        int unsigned n;
        start_ph = ph;
        step_res.delete();
        case (ph)
            PH_HEADER: take_header(v);
            PH_PIXELS: begin
                if (fill != 0) begin
                    n = runc; fill = 0; runc = 0;
                    for (int k = 0; k < n && ph == PH_PIXELS; k++) place_line_byte(v);
                end else if (v < RLE_MARK) place_line_byte(v);
                else if ((v & 8'h3F) != 0) begin
                    if ((v & 8'h3F) > left) raise_error(ERR_OVERRUN);
                    else begin
                        fill = 1; runc = v & 8'h3F;
                    end
                end
            end
            PH_MARKER: begin
                if (v == PAL_MARKER) begin
                    ph = PH_PALETTE; ppos = 0; pstage = 0;
                end else begin
                    mscan++;
                    if (mscan >= MARKER_TRIES) raise_error(ERR_NOMARKER);
                end
            end
            PH_PALETTE: begin
                if (ppos % 3 == 0) pstage = v;
                else if (ppos % 3 == 1) pstage = (pstage & 8'hFF) | (v << 8);
                else begin
                    emit(KIND_PALETTE, pstage & 8'hFF, pstage >> 8, v, ppos / 3, 0, 0, 0,
                         0, (ppos / 3 == PAL_LAST));
                    if (ppos / 3 == PAL_LAST) ph = PH_DONE;
                end
                ppos = (ppos + 1) & 10'h3FF;
            end
            default: ;
        endcase
        if (eof) begin
            if (start_ph != PH_ERROR && ph != PH_ERROR && ph != PH_DONE) begin
                step_res.delete();
                raise_error(ERR_TRUNCATED);
            end
            clear_decoder();
        end
        if (step_res.size() > 0) step_res[step_res.size() - 1].run_end = 1'b1;
        foreach (step_res[i]) decoded_q.push_back(step_res[i]);
    endfunction

    // Drives one byte beat, predicting its results when it is accepted.
    task automatic send_byte(input logic [7:0] v, input logic eof = 1'b0);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tlast  <= eof;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_byte(v, eof);
        beats_sent++;
        @(negedge aclk);
    endtask

    task automatic send_header(input int unsigned w, input int unsigned h,
                               input int unsigned np, input int unsigned lb,
                               input int bad_field = -1);
        logic [7:0] hb [128];
        for (int i = 0; i < 128; i++) hb[i] = 8'($urandom);
        hb[0] = 8'd10; hb[1] = 8'd5; hb[2] = 8'd1; hb[3] = 8'd8;
        {hb[5], hb[4]} = 16'd7;
        {hb[7], hb[6]} = 16'd3;
        {hb[9], hb[8]} = 16'(7 + w - 1);
        {hb[11], hb[10]} = 16'(3 + h - 1);
        hb[65] = 8'(np);
        {hb[67], hb[66]} = 16'(lb);
        if (bad_field >= 0 && bad_field < 4) hb[bad_field] = hb[bad_field] ^ 8'h40;
        for (int i = 0; i < 128; i++) send_byte(hb[i]);
    endtask

    // Encodes one plane line, mixing literals, runs, zero-count bytes.
    task automatic send_line(input int unsigned lb);
        int unsigned rem, n;
        rem = lb;
        while (rem > 0) begin
            case ($urandom_range(5))
                0, 1: begin
                    send_byte(8'($urandom_range(8'hBF)));
                    rem--;
                end
                2: begin
                    n = $urandom_range(1, (rem > 63) ? 63 : rem);
                    send_byte(8'(RLE_MARK | n));
                    send_byte(8'($urandom));
                    rem -= n;
                end
                3: send_byte(RLE_MARK);
                default: begin
                    send_byte(8'hC1);
                    send_byte(8'($urandom_range(8'hC0, 8'hFF)));
                    rem--;
                end
            endcase
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (decoded_q.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    // Receiver side: stall pattern plus an optional long hold-off.
    always @(negedge aclk) begin
        if (hold_recv > 0) begin
            m_tready <= 1'b0;
            hold_recv <= hold_recv - 1;
        end else m_tready <= aresetn && ($urandom_range(99) >= recv_stall_pct);
    end

    // Compares each result beat with the oldest prediction.
    always @(posedge aclk) begin
        pcx_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '0;
            got.kind = kind_t'(m_tuser[1:0]);
            got.image_end = m_tuser[2];
            got.run_end = m_tlast;
            {got.error_code, got.dpi_y, got.dpi_x, got.row, got.column,
             got.blue, got.green, got.red} = m_tdata[92:0];
            beats_seen++;
            if (decoded_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat %h", $time, got);
            end else begin
                want = decoded_q.pop_front();
                if (got !== want) begin
                    errors++;
                    $display("%0t: mismatch expected %p actual %p", $time, want, got);
                end
            end
            if (m_tdata[95:93] !== 3'b0) begin
                errors++;
                $display("%0t: pad bits expected 0 actual %b", $time, m_tdata[95:93]);
            end
        end
    end

    // A file that ends in the middle of its header.
    task automatic test_truncated_header();
        send_byte(8'd10); send_byte(8'd5); send_byte(8'd1); send_byte(8'd8);
        repeat (7) send_byte(8'($urandom));
        send_byte(8'($urandom), 1'b1);
    endtask

    // A small RGB image with a pad byte per line, one idling pattern per row.
    task automatic test_rgb_image();
        send_header(5, 3, 3, 6);
        for (int r = 0; r < 3; r++) begin
            send_idle_pct  = (r == 1) ? 0 : ((r == 0) ? 52 : 35);
            recv_stall_pct = (r == 0) ? 0 : ((r == 1) ? 52 : 35);
            for (int p = 0; p < 3; p++) send_line(6);
        end
        send_idle_pct = 0; recv_stall_pct = 0;
        repeat (2) send_byte(8'($urandom));
        send_byte(8'($urandom), 1'b1);
        wait_drained();
    endtask

    // Full-length runs on a wide index line while the receiver holds off,
    // then an overrun at a count byte and sticky bytes until end of file.
    task automatic test_backpressure();
        send_header(125, 2, 1, 126);
        fork
            hold_recv = 300;
            begin
                repeat (2) begin
                    send_byte(8'hFF); send_byte(8'($urandom));
                end
                repeat (4) send_byte(8'($urandom_range(8'hBF)));
                send_byte(8'hFF); send_byte(8'($urandom));
                send_byte(8'hFF);
            end
        join
        repeat (2) send_byte(8'($urandom));
        send_byte(8'($urandom), 1'b1);
        wait_drained();
    endtask

    initial begin
        clear_decoder();
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_truncated_header();
        test_rgb_image();
        test_backpressure();
        wait_drained();
        $display("Sent %0d byte beats, checked %0d result beats.", beats_sent, beats_seen);
        $display("Covered a cut-off header, RLE-coded RGB lines under several idle mixes,");
        $display("full-length index runs behind a long receiver hold-off, and an overrun.");
        if (errors == 0) $display("tb_pcx_image_stream_decoder: PASS");
        else $display("tb_pcx_image_stream_decoder: FAIL");
        $finish;
    end

    initial begin
        #20ms;
        $display("tb_pcx_image_stream_decoder: FAIL");
        $finish;
    end

endmodule
